FILE: sv/assert_macros.svh
// Assertion macros shared by the queue and back-end modules of the vector dot and distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is low.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same check, named for rules that must hold on every edge after reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    `ASSERT_SYNC(label, clk, rst_n, prop, msg)

`endif

FILE: sv/i7vd_pkg.sv
// Package with types and constants of the vector dot and distance block.
package i7vd_pkg;

    localparam int MAX_LANES = 4;
    localparam int ELEM_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int TERM_W    = 2 * ELEM_W;
    localparam int SUM_W     = TERM_W + 2;
    localparam int ACC_W     = 32;
    localparam int RESULT_W  = 31;
    localparam int DATA_W    = MAX_LANES * BYTE_W;
    localparam int COUNT_W   = 3;

    localparam int DEF_LANES     = 4;
    localparam int DEF_MID_DEPTH = 4;
    localparam int DEF_OUT_DEPTH = 2;

    typedef enum logic {
        MODE_DOT     = 1'b0,
        MODE_SQ_DIST = 1'b1
    } t_mode;

    typedef struct packed {
        logic                                last;
        logic [MAX_LANES-1:0][TERM_W-1:0]    terms;
    } t_mid_word;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: sv/i7vd_fifo.sv
// Small register-based queue used between the front and back and at the output.
module i7vd_fifo
    import i7vd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output t_q_status        o_status
);

`include "assert_macros.svh"

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wptr, n_wptr;
    logic [ADDR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              wr_en, rd_en;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign wr_en = i_push && !o_status.full;
    assign rd_en = i_pop && !o_status.empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == ADDR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == ADDR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "fifo count above depth")
    `ASSERT_SYNC(a_count_up, i_clk, i_rst_n, (wr_en && !rd_en) |=> (r_count == $past(r_count) + 1'b1), "fifo count did not rise on push")
    `ASSERT_SYNC(a_ptr_gap, i_clk, i_rst_n, (r_count == '0) |-> (r_wptr == r_rptr), "empty fifo with pointers apart")

endmodule

FILE: sv/i7vd_front.sv
// Front end: holds the mode register and turns each input word into lane terms.
module i7vd_front
    import i7vd_pkg::*;
#(
    parameter int LANES = DEF_LANES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_data,
    input  logic [DATA_W-1:0]  i_a_lanes,
    input  logic [DATA_W-1:0]  i_b_lanes,
    input  logic [COUNT_W-1:0] i_lane_count,
    input  logic               i_last,
    output t_mid_word          o_word
);

    t_mode r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DOT;
        end else if (i_cfg_valid) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    assign o_word.last = i_last;

    // Lanes at or above LANES never enable, which also saturates the count.
    for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
        if (i < LANES) begin : g_active
            localparam logic [COUNT_W-1:0] LaneIdx = COUNT_W'(i);
            logic [ELEM_W-1:0] x, y, d, op0, op1;
            logic [TERM_W-1:0] prod;
            logic              lane_on;

            assign x = i_a_lanes[i*BYTE_W +: ELEM_W];
            assign y = i_b_lanes[i*BYTE_W +: ELEM_W];
            assign d = (x >= y) ? (x - y) : (y - x);
            assign op0 = (r_mode == MODE_SQ_DIST) ? d : x;
            assign op1 = (r_mode == MODE_SQ_DIST) ? d : y;
            assign prod = TERM_W'(op0) * TERM_W'(op1);
            assign lane_on = (LaneIdx < i_lane_count);
            assign o_word.terms[i] = lane_on ? prod : '0;
        end else begin : g_idle
            assign o_word.terms[i] = '0;
        end
    end

endmodule

FILE: sv/i7vd_back.sv
// Back end: adds the lane terms into the running sum and issues totals.
module i7vd_back
    import i7vd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mid_word           i_mid_word,
    input  t_q_status           i_mid_status,
    input  t_q_status           i_out_status,
    output logic                o_mid_pop,
    output logic                o_out_push,
    output logic [RESULT_W-1:0] o_out_data
);

`include "assert_macros.svh"

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [SUM_W-1:0] term_sum;

    always_comb begin
        term_sum = '0;
        for (int i = 0; i < MAX_LANES; i++) begin
            term_sum = term_sum + SUM_W'(i_mid_word.terms[i]);
        end
    end

    // A final word waits until the output queue has room for its total.
    assign o_mid_pop  = !i_mid_status.empty && (!i_mid_word.last || !i_out_status.full);
    assign o_out_push = o_mid_pop && i_mid_word.last;
    assign n_acc      = r_acc + ACC_W'(term_sum);
    assign o_out_data = n_acc[RESULT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (o_mid_pop) begin
            r_acc <= i_mid_word.last ? '0 : n_acc;
        end
    end

    `ASSERT_SYNC(a_acc_clear, i_clk, i_rst_n, o_out_push |=> (r_acc == '0), "sum not cleared after total")

endmodule

FILE: sv/int7_vector_dot_or_sq_distance_top.sv
// Top level of the streaming dot product and squared distance block.
// Each word carries up to four 7-bit element pairs and is taken whenever full is low, one word
// per clock sustained: the front computes one 7x7 product per lane as the word enters the
// middle queue, and the back adds the lane terms into the 32-bit running sum at one word per
// cycle while the middle queue is not empty and, for a last word, the output queue has room. A
// total goes through the middle and output queues to the result side. The mode bit (0 dot
// product, 1 squared distance) is written through the configuration channel, which is always
// ready, and applies to words taken after the write. The result is the low 31 bits of the sum.
module int7_vector_dot_or_sq_distance_top
    import i7vd_pkg::*;
#(
    parameter int LANES     = DEF_LANES,
    parameter int MID_DEPTH = DEF_MID_DEPTH,
    parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [DATA_W-1:0]   i_a_lanes,
    input  logic [DATA_W-1:0]   i_b_lanes,
    input  logic [COUNT_W-1:0]  i_lane_count,
    input  logic                i_last,
    output logic                empty,
    input  logic                pop,
    output logic [RESULT_W-1:0] o_result
);

    t_mid_word           front_word, mid_word;
    t_q_status           mid_status, out_status;
    logic                mid_pop, out_push;
    logic [RESULT_W-1:0] out_data;

    assign o_cfg_ready = 1'b1;

    i7vd_front #(
        .LANES (LANES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_a_lanes    (i_a_lanes),
        .i_b_lanes    (i_b_lanes),
        .i_lane_count (i_lane_count),
        .i_last       (i_last),
        .o_word       (front_word)
    );

    i7vd_fifo #(
        .WIDTH ($bits(t_mid_word)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (front_word),
        .i_pop    (mid_pop),
        .o_rdata  (mid_word),
        .o_status (mid_status)
    );

    i7vd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mid_word   (mid_word),
        .i_mid_status (mid_status),
        .i_out_status (out_status),
        .o_mid_pop    (mid_pop),
        .o_out_push   (out_push),
        .o_out_data   (out_data)
    );

    i7vd_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (out_push),
        .i_wdata  (out_data),
        .i_pop    (pop),
        .o_rdata  (o_result),
        .o_status (out_status)
    );

    assign full  = mid_status.full;
    assign empty = out_status.empty;

endmodule

FILE: tb/tb_int7_vector_dot_or_sq_distance_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming dot product and squared distance block.
module tb_int7_vector_dot_or_sq_distance_top;
    import i7vd_pkg::*;

    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int PIPE_LATENCY      = 8;
    localparam int WATCHDOG_CYCLES   = 4000;
    localparam int FLOOD_WORDS       = 40;
    localparam int MAX_REPORTS       = 10;

    localparam logic [DATA_W-1:0] ALL_ZERO = 32'h0000_0000;
    localparam logic [DATA_W-1:0] ALL_MAX  = 32'h7F7F_7F7F;
    localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] ALL_HIGH = 32'h8080_8080;

    // Tracks the running sum word by word and holds the totals still owed by the block.
    class vector_sum_tracker;
        t_mode               mode;
        logic [ACC_W-1:0]    running_sum;
        logic [RESULT_W-1:0] pending_totals[$];
        int                  errors;

        function new();
            mode        = MODE_DOT;
            running_sum = '0;
            errors      = 0;
        endfunction

        function void set_mode(t_mode m);
            mode = m;
        endfunction

        function void note_word(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                logic [COUNT_W-1:0] count, logic last);
            int unsigned       used;
            logic [ELEM_W-1:0] x;
            logic [ELEM_W-1:0] y;
            logic [ELEM_W-1:0] diff;
            logic [TERM_W-1:0] term;
            used = (count > MAX_LANES) ? MAX_LANES : count;
            for (int i = 0; i < used; i++) begin
                // Only the low seven bits of each byte take part.
                x = a[BYTE_W*i +: ELEM_W];
                y = b[BYTE_W*i +: ELEM_W];
                if (mode == MODE_SQ_DIST) begin
                    diff = (x >= y) ? x - y : y - x;
                    term = diff * diff;
                end else begin
                    term = x * y;
                end
                running_sum = running_sum + ACC_W'(term);
            end
            if (last) begin
                pending_totals.push_back(running_sum[RESULT_W-1:0]);
                running_sum = '0;
            end
        endfunction

        function void check_total(logic [RESULT_W-1:0] got);
            logic [RESULT_W-1:0] want;
            if (pending_totals.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result word %0d with no total pending", $time, got);
                return;
            end
            want = pending_totals.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result mismatch: expected %0d, actual %0d",
                             $time, want, got);
            end
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_data   = 1'b0;
    logic                push         = 1'b0;
    logic                full;
    logic [DATA_W-1:0]   i_a_lanes    = '0;
    logic [DATA_W-1:0]   i_b_lanes    = '0;
    logic [COUNT_W-1:0]  i_lane_count = '0;
    logic                i_last       = 1'b0;
    logic                empty;
    logic                pop          = 1'b0;
    logic [RESULT_W-1:0] o_result;

    vector_sum_tracker tracker;
    bit                hold_off_req   = 1'b0;
    int                stalled_cycles = 0;
    logic [15:0]       pop_pattern    = '1;
    int                pat_pos        = 0;

    int7_vector_dot_or_sq_distance_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_a_lanes    (i_a_lanes),
        .i_b_lanes    (i_b_lanes),
        .i_lane_count (i_lane_count),
        .i_last       (i_last),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // A word taken on the same edge as a mode write still sees the old mode.
            if (push && !full)
                tracker.note_word(i_a_lanes, i_b_lanes, i_lane_count, i_last);
            if (i_cfg_valid && o_cfg_ready)
                tracker.set_mode(t_mode'(i_cfg_data));
            if (pop && !empty)
                tracker.check_total(o_result);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_CYCLES) begin
            $display("tb_int7_vector_dot_or_sq_distance_top: errors");
            $finish;
        end
    end

    // Result side: a fresh 16-bit pop pattern now and then, plus one long hold-off on request.
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            if (pat_pos == 0) begin
                case ($urandom_range(0, 4))
                    0: pop_pattern = '1;
                    1: pop_pattern = 16'($urandom);
                    2: pop_pattern = 16'($urandom & $urandom);
                    3: pop_pattern = 16'($urandom | $urandom);
                    default: pop_pattern = 16'h00FF;
                endcase
            end
            pop <= pop_pattern[pat_pos];
            pat_pos = (pat_pos + 1) % 16;
        end
    end

    task automatic send_word(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                             input logic [COUNT_W-1:0] count, input logic last);
        push         <= 1'b1;
        i_a_lanes    <= a;
        i_b_lanes    <= b;
        i_lane_count <= count;
        i_last       <= last;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic sender_idle(input int cycles);
        if (cycles > 0) begin
            push <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    task automatic wait_results();
        while (tracker.pending_totals.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        push <= 1'b0;
        wait_results();
        // A word without last may still be on its way through the queues.
        repeat (PIPE_LATENCY) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 8'h7F;
            2: return BYTE_W'($urandom);
            default: return BYTE_W'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic rand_word(output logic [DATA_W-1:0] a, output logic [DATA_W-1:0] b,
                             output logic [COUNT_W-1:0] count, output logic last);
        for (int i = 0; i < MAX_LANES; i++) begin
            a[BYTE_W*i +: BYTE_W] = rand_elem();
            b[BYTE_W*i +: BYTE_W] = rand_elem();
        end
        case ($urandom_range(0, 19))
            0: count = '0;
            1: count = COUNT_W'($urandom_range(MAX_LANES + 1, 7));
            default: count = COUNT_W'($urandom_range(1, MAX_LANES));
        endcase
        last = ($urandom_range(0, 7) == 0);
    endtask

    task automatic run_random_phase(input int words);
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [COUNT_W-1:0] count;
        logic               last;
        int                 sent;
        int                 burst;
        int                 gap;
        sent = 0;
        while (sent < words) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < words; i++) begin
                rand_word(a, b, count, last);
                send_word(a, b, count, last);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            sender_idle(gap);
        end
    endtask

    // Every word closes a vector, so totals pile up while the result side holds off.
    task automatic flood_during_hold_off();
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [COUNT_W-1:0] count;
        logic               last;
        hold_off_req = 1'b1;
        for (int i = 0; i < FLOOD_WORDS; i++) begin
            rand_word(a, b, count, last);
            send_word(a, b, count, 1'b1);
        end
    endtask

    initial begin
        tracker = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_mode(MODE_DOT);
        send_word(ALL_ZERO, ALL_ZERO, 3'd4, 1'b1);
        send_word(ALL_MAX, ALL_MAX, 3'd4, 1'b1);
        send_word(ALL_ONES, ALL_ONES, 3'd4, 1'b1);
        send_word(ALL_HIGH, ALL_MAX, 3'd4, 1'b1);
        send_word(32'h0403_0201, 32'h0101_0101, 3'd0, 1'b0);
        send_word(32'h0403_0201, 32'h0505_0505, 3'd1, 1'b0);
        send_word(32'h0403_0201, 32'h0505_0505, 3'd2, 1'b0);
        send_word(32'h0403_0201, 32'h0505_0505, 3'd3, 1'b0);
        send_word(32'h0403_0201, 32'h0505_0505, 3'd0, 1'b1);
        send_word(ALL_MAX, 32'h0102_0304, 3'd5, 1'b1);
        send_word(ALL_MAX, 32'h0102_0304, 3'd6, 1'b1);
        send_word(ALL_MAX, 32'h0102_0304, 3'd7, 1'b1);
        send_word(ALL_ZERO, ALL_ZERO, 3'd0, 1'b1);

        write_mode(MODE_SQ_DIST);
        send_word(ALL_MAX, ALL_ZERO, 3'd4, 1'b1);
        send_word(ALL_ZERO, ALL_MAX, 3'd4, 1'b1);
        send_word(32'h5A5A_5A5A, 32'h5A5A_5A5A, 3'd4, 1'b1);
        send_word(ALL_ONES, ALL_HIGH, 3'd4, 1'b1);
        send_word(32'h007F_1005, 32'h7F00_0510, 3'd2, 1'b0);
        send_word(32'h007F_1005, 32'h7F00_0510, 3'd4, 1'b1);
        send_word(ALL_MAX, 32'h0102_0304, 3'd7, 1'b1);

        run_random_phase(225);

        write_mode(MODE_DOT);
        run_random_phase(100);
        flood_during_hold_off();
        run_random_phase(85);

        write_mode(MODE_SQ_DIST);
        run_random_phase(110);
        sender_idle(1);
        wait_results();
        run_random_phase(115);

        write_mode(t_mode'($urandom_range(0, 1)));
        run_random_phase(225);

        push <= 1'b0;
        wait_results();
        repeat (PIPE_LATENCY) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.pending_totals.size() == 0)
            $display("tb_int7_vector_dot_or_sq_distance_top: clean");
        else
            $display("tb_int7_vector_dot_or_sq_distance_top: errors");
        $finish;
    end

endmodule
